>>> sv/spi_banked_register_and_buffer_slave_macros.svh
// Assertion macros for the SPI banked register and buffer slave.
`ifndef SPI_BANKED_REGISTER_AND_BUFFER_SLAVE_MACROS_SVH
`define SPI_BANKED_REGISTER_AND_BUFFER_SLAVE_MACROS_SVH
`ifndef SYNTH
`define SBRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBRB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SBRB_ASSERT(lbl, prop, msg)
`define SBRB_NEVER(lbl, cond, msg)
`endif
`endif

>>> sv/sbrb_pkg.sv
// Shared constants and the register reset table of the SPI slave.
`default_nettype none
package sbrb_pkg;

  localparam logic [2:0] OP_RCR = 3'd0;
  localparam logic [2:0] OP_RBM = 3'd1;
  localparam logic [2:0] OP_WCR = 3'd2;
  localparam logic [2:0] OP_WBM = 3'd3;
  localparam logic [2:0] OP_BFS = 3'd4;
  localparam logic [2:0] OP_BFC = 3'd5;
  localparam logic [2:0] OP_SRC = 3'd7;

  localparam logic [4:0] ADDR_COMMON = 5'h1B;
  localparam logic [6:0] SLOT_ECON2  = 7'h1E;
  localparam logic [6:0] SLOT_ECON1  = 7'h1F;
  localparam logic [7:0] AUTOINC_BIT = 8'h80;

  // Power-on value of each register file entry (bank * 32 + address).
  function automatic logic [7:0] reg_default(input logic [6:0] slot);
    logic [7:0] v;
    v = 8'h00;
    case (slot)
      7'h00, 7'h08, 7'h0C: v = 8'hFA;
      7'h01, 7'h09, 7'h0D: v = 8'h05;
      7'h0A:               v = 8'hFF;
      7'h0B:               v = 8'h1F;
      7'h38:               v = 8'hA1;
      7'h48:               v = 8'h0F;
      7'h49:               v = 8'h37;
      7'h4B:               v = 8'h06;
      7'h72:               v = 8'h06;
      7'h75:               v = 8'h04;
      7'h79:               v = 8'h10;
      7'h1D:               v = 8'h01;
      7'h1E:               v = 8'h80;
      default:             v = 8'h00;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> sv/spi_banked_register_and_buffer_slave.sv
// Top level: SPI command slave with banked register file and packet buffer.
//
//  channel | direction | handshake            | payload
//  in_     | host->blk | in_valid / in_stall   | in_frame_start, in_mosi_byte
//  out_    | blk->host | out_valid / out_stall | out_miso_byte
//
// The register RAM and buffer RAM reads are issued when a request is accepted;
// the registered read data then feeds the read-modify-write and the output reg.
// A request is accepted while an earlier result still waits on out_stall;
// the writeback step then holds until the output register is free.
// Reset (and soft reset command) restores registers via per-entry valid bits
// at once; no clearing pass. Buffer contents are not reset.
`default_nettype none
`include "spi_banked_register_and_buffer_slave_macros.svh"
module spi_banked_register_and_buffer_slave #(
  parameter int BUFFER_BYTES = 8192,
  parameter int BANK_COUNT   = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_frame_start,
  input  wire logic [7:0] in_mosi_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_miso_byte
);
  localparam int BUF_AW = $clog2(BUFFER_BYTES);

  typedef enum logic [1:0] {PH_IDLE, PH_REG, PH_BUF} phase_t;

  phase_t       phase_r;
  logic [2:0]   pend_op_r;
  logic [4:0]   pend_addr_r;
  logic         dummy_r;
  logic         busy_r;
  logic         start_r;
  logic [7:0]   byte_r;
  logic         out_valid_r;
  logic [7:0]   out_byte_r;
  logic [127:0] vld_r;
  // Bank 0 low entries (pointers) and ECON1/ECON2 live in flops.
  logic [7:0]   shadow_r [16];
  logic [7:0]   econ1_r;
  logic [7:0]   econ2_r;

  logic         accept, out_free, done;
  logic [1:0]   bank;
  logic [6:0]   slot;
  logic         in_shadow;
  logic         wants_dummy;
  logic [7:0]   reg_rd, buf_rd, regval, newv, result;
  logic [15:0]  erdpt, ewrpt, erxst, erxnd;
  logic [16:0]  rd_mod, wr_mod;
  logic [15:0]  rd_next, wr_next;
  logic         reg_we, buf_we, is_modify;

  // Pointer increment with wrap at the buffer end.
  function automatic logic [15:0] bump(input logic [15:0] p);
    logic [16:0] n;
    n = {1'b0, p} + 17'd1;
    if (n >= 17'(BUFFER_BYTES)) begin
      n = 17'd0;
    end
    return n[15:0];
  endfunction

  // Bank bits folded into the implemented bank count.
  function automatic logic [1:0] bank_of(input logic [1:0] v);
    logic [2:0] t;
    t = {1'b0, v};
    for (int i = 0; i < 3; i++) begin
      if (t >= 3'(BANK_COUNT)) begin
        t = t - 3'(BANK_COUNT);
      end
    end
    return t[1:0];
  endfunction

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign done     = busy_r && out_free;
  assign in_stall = busy_r;
  assign out_valid     = out_valid_r;
  assign out_miso_byte = out_byte_r;

  // Banked address resolution
  assign bank = bank_of(econ1_r[1:0]);
  assign slot = (pend_addr_r >= sbrb_pkg::ADDR_COMMON) ? {2'b00, pend_addr_r}
                                                       : {bank, pend_addr_r};
  assign in_shadow = (slot[6:4] == 3'd0) || (slot == sbrb_pkg::SLOT_ECON2) ||
                     (slot == sbrb_pkg::SLOT_ECON1);
  // MAC/MII registers return a dummy byte first
  assign wants_dummy = (pend_addr_r < sbrb_pkg::ADDR_COMMON) &&
                       (((bank == 2'd2) && (pend_addr_r < 5'h1A)) ||
                        ((bank == 2'd3) && ((pend_addr_r <= 5'h05) ||
                                            (pend_addr_r == 5'h0A))));

  assign erdpt = {shadow_r[1], shadow_r[0]};
  assign ewrpt = {shadow_r[3], shadow_r[2]};
  assign erxst = {shadow_r[9], shadow_r[8]};
  assign erxnd = {shadow_r[11], shadow_r[10]};
  assign rd_mod = {1'b0, erdpt} % 17'(BUFFER_BYTES);
  assign wr_mod = {1'b0, ewrpt} % 17'(BUFFER_BYTES);
  // Read pointer wraps from the RX ring end back to its start
  assign rd_next = (erdpt == erxnd) ? erxst : bump(erdpt);
  assign wr_next = bump(ewrpt);

  always_comb begin
    if (slot[6:4] == 3'd0) begin
      regval = shadow_r[slot[3:0]];
    end else if (slot == sbrb_pkg::SLOT_ECON2) begin
      regval = econ2_r;
    end else if (slot == sbrb_pkg::SLOT_ECON1) begin
      regval = econ1_r;
    end else if (vld_r[slot]) begin
      regval = reg_rd;
    end else begin
      regval = sbrb_pkg::reg_default(slot);
    end
  end

  always_comb begin
    newv      = byte_r;
    is_modify = 1'b0;
    unique case (pend_op_r)
      sbrb_pkg::OP_WCR: begin
        newv = byte_r;
        is_modify = 1'b1;
      end
      sbrb_pkg::OP_BFS: begin
        newv = regval | byte_r;
        is_modify = 1'b1;
      end
      sbrb_pkg::OP_BFC: begin
        newv = regval & ~byte_r;
        is_modify = 1'b1;
      end
      default: begin
        newv = byte_r;
        is_modify = 1'b0;
      end
    endcase
  end

  always_comb begin
    result = 8'h00;
    if (!start_r && (phase_r == PH_REG) && (pend_op_r == sbrb_pkg::OP_RCR) &&
        !(wants_dummy && !dummy_r)) begin
      result = regval;
    end else if (!start_r && (phase_r == PH_BUF) && (pend_op_r == sbrb_pkg::OP_RBM)) begin
      result = buf_rd;
    end
  end

  assign reg_we = done && !start_r && (phase_r == PH_REG) && is_modify && !in_shadow;
  assign buf_we = done && !start_r && (phase_r == PH_BUF) && (pend_op_r == sbrb_pkg::OP_WBM);

  sbrb_ram #(.WIDTH(8), .DEPTH(128)) u_reg_ram (
    .clk     (clk),
    .wr_en   (reg_we),
    .wr_addr (slot),
    .wr_data (newv),
    .rd_en   (accept),
    .rd_addr (slot),
    .rd_data (reg_rd)
  );

  sbrb_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_buf_ram (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (wr_mod[BUF_AW-1:0]),
    .wr_data (byte_r),
    .rd_en   (accept),
    .rd_addr (rd_mod[BUF_AW-1:0]),
    .rd_data (buf_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      pend_op_r   <= 3'd0;
      pend_addr_r <= 5'd0;
      dummy_r     <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      for (int i = 0; i < 16; i++) begin
        shadow_r[i] <= sbrb_pkg::reg_default(7'(i));
      end
      econ1_r <= sbrb_pkg::reg_default(sbrb_pkg::SLOT_ECON1);
      econ2_r <= sbrb_pkg::reg_default(sbrb_pkg::SLOT_ECON2);
    end else begin
      if (out_valid_r && !out_stall && !done) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        busy_r  <= 1'b1;
        start_r <= in_frame_start;
        byte_r  <= in_mosi_byte;
      end
      if (done) begin
        busy_r      <= 1'b0;
        out_valid_r <= 1'b1;
        out_byte_r  <= result;
        if (start_r) begin
          pend_op_r   <= byte_r[7:5];
          pend_addr_r <= byte_r[4:0];
          dummy_r     <= 1'b0;
          if (byte_r[7:5] == sbrb_pkg::OP_SRC) begin
            phase_r <= PH_IDLE;
            vld_r   <= '0;
            for (int i = 0; i < 16; i++) begin
              shadow_r[i] <= sbrb_pkg::reg_default(7'(i));
            end
            econ1_r <= sbrb_pkg::reg_default(sbrb_pkg::SLOT_ECON1);
            econ2_r <= sbrb_pkg::reg_default(sbrb_pkg::SLOT_ECON2);
          end else if ((byte_r[7:5] == sbrb_pkg::OP_RBM) ||
                       (byte_r[7:5] == sbrb_pkg::OP_WBM)) begin
            phase_r <= PH_BUF;
          end else begin
            phase_r <= PH_REG;
          end
        end else begin
          unique case (phase_r)
            PH_REG: begin
              if (pend_op_r == sbrb_pkg::OP_RCR) begin
                if (wants_dummy && !dummy_r) begin
                  dummy_r <= 1'b1;
                end
              end else begin
                phase_r <= PH_IDLE;
                if (is_modify) begin
                  if (slot[6:4] == 3'd0) begin
                    shadow_r[slot[3:0]] <= newv;
                  end else if (slot == sbrb_pkg::SLOT_ECON2) begin
                    econ2_r <= newv;
                  end else if (slot == sbrb_pkg::SLOT_ECON1) begin
                    econ1_r <= newv;
                  end else begin
                    vld_r[slot] <= 1'b1;
                  end
                end
              end
            end
            PH_BUF: begin
              if ((econ2_r & sbrb_pkg::AUTOINC_BIT) != 8'h00) begin
                if (pend_op_r == sbrb_pkg::OP_RBM) begin
                  shadow_r[0] <= rd_next[7:0];
                  shadow_r[1] <= rd_next[15:8];
                end else begin
                  shadow_r[2] <= wr_next[7:0];
                  shadow_r[3] <= wr_next[15:8];
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  `SBRB_ASSERT(a_accept_busy, accept |=> busy_r, "accepted request not in progress")
  `SBRB_ASSERT(a_done_out, done |=> out_valid_r, "finished request produced no result")
  `SBRB_NEVER(a_ram_collide, accept && (reg_we || buf_we), "RAM read issued during writeback")

endmodule
`default_nettype wire

>>> sv/sbrb_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sbrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench for the SPI banked register and buffer slave.
`default_nettype none
module tb_top;

  localparam int          BUF_N      = 8192;
  localparam int          BANK_N     = 4;
  localparam int          IDLE_LIMIT = 5000;
  localparam logic [2:0]  OP_UNUSED  = 3'd6;
  // banked pointer registers (bank 0, low byte)
  localparam logic [4:0]  ERDPTL     = 5'h00;
  localparam logic [4:0]  EWRPTL     = 5'h02;
  localparam logic [4:0]  ERXSTL     = 5'h08;
  localparam logic [4:0]  ERXNDL     = 5'h0A;
  localparam logic [4:0]  ECON2_ADR  = 5'h1E;
  localparam logic [4:0]  ECON1_ADR  = 5'h1F;

  typedef struct {
    bit       start;
    bit [7:0] data;
    bit [7:0] miso;  // predicted response byte
    bit       drain; // hold until all responses are back
  } request_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_frame_start = 1'b0;
  logic [7:0] in_mosi_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_miso_byte;

  spi_banked_register_and_buffer_slave u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_frame_start(in_frame_start),
    .in_mosi_byte  (in_mosi_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_miso_byte (out_miso_byte)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Slave shadow: frame decode state, register file and packet buffer.
  // ---------------------------------------------------------------------------
  logic [1:0] sh_phase;   // 0 idle, 1 register access, 2 buffer streaming
  logic [2:0] sh_op;
  logic [4:0] sh_addr;
  bit         sh_dummy;
  logic [7:0] sh_regs [128];
  logic [7:0] sh_mem [BUF_N];
  bit         sh_written [BUF_N];

  request_t   pend_q[$];   // requests still to be sent
  logic [7:0] miso_q[$];   // responses owed by the slave
  bit         drain_next;
  int         errors;
  int         sent;
  int         gap_end = 1 << 30;
  int         in_gap;
  int         out_gap;
  int         idle_cycles;

  function automatic void regs_to_defaults();
    for (int i = 0; i < 128; i++) sh_regs[i] = 8'h00;
    sh_regs[7'h00] = 8'hFA; sh_regs[7'h01] = 8'h05;   // read pointer
    sh_regs[7'h08] = 8'hFA; sh_regs[7'h09] = 8'h05;   // rx start
    sh_regs[7'h0A] = 8'hFF; sh_regs[7'h0B] = 8'h1F;   // rx end
    sh_regs[7'h0C] = 8'hFA; sh_regs[7'h0D] = 8'h05;
    sh_regs[7'h38] = 8'hA1;
    sh_regs[7'h48] = 8'h0F; sh_regs[7'h49] = 8'h37;
    sh_regs[7'h4B] = 8'h06;
    sh_regs[7'h72] = 8'h06; sh_regs[7'h75] = 8'h04; sh_regs[7'h79] = 8'h10;
    sh_regs[7'h1D] = 8'h01;                            // clock ready
    sh_regs[sbrb_pkg::SLOT_ECON2] = sbrb_pkg::AUTOINC_BIT;
  endfunction

  function automatic logic [1:0] cur_bank();
    return 2'(int'(sh_regs[sbrb_pkg::SLOT_ECON1][1:0]) % BANK_N);
  endfunction

  function automatic logic [6:0] slot_of(logic [4:0] a);
    if (a >= sbrb_pkg::ADDR_COMMON) return {2'b00, a};
    return {cur_bank(), a};
  endfunction

  // MAC and MII registers put a dummy byte ahead of read data
  function automatic bit has_dummy(logic [4:0] a);
    if (a >= sbrb_pkg::ADDR_COMMON) return 1'b0;
    if (cur_bank() == 2'd2) return a < 5'h1A;
    if (cur_bank() == 2'd3) return a <= 5'h05 || a == 5'h0A;
    return 1'b0;
  endfunction

  function automatic logic [15:0] ptr_of(logic [4:0] lo);
    return {sh_regs[lo + 1], sh_regs[lo]};
  endfunction

  function automatic logic [15:0] ptr_next(logic [15:0] p);
    logic [16:0] n;
    n = p + 17'd1;
    if (n >= BUF_N) n = 17'd0;
    return n[15:0];
  endfunction

  function automatic void ptr_store(logic [4:0] lo, logic [15:0] v);
    sh_regs[lo]     = v[7:0];
    sh_regs[lo + 1] = v[15:8];
  endfunction

  // Advance the shadow by one byte slot; returns the byte shifted out.
  function automatic logic [7:0] slave_byte(bit start, logic [7:0] b);
    logic [7:0]  r;
    logic [6:0]  s;
    logic [15:0] p;
    bit          ai;
    r  = 8'h00;
    ai = (sh_regs[sbrb_pkg::SLOT_ECON2] & sbrb_pkg::AUTOINC_BIT) != 8'h00;
    if (start) begin
      sh_op    = b[7:5];
      sh_addr  = b[4:0];
      sh_dummy = 1'b0;
      if (sh_op == sbrb_pkg::OP_SRC) begin
        regs_to_defaults();
        sh_phase = 2'd0;
      end else if (sh_op == sbrb_pkg::OP_RBM || sh_op == sbrb_pkg::OP_WBM) begin
        sh_phase = 2'd2;
      end else begin
        sh_phase = 2'd1;
      end
    end else if (sh_phase == 2'd1) begin
      s = slot_of(sh_addr);
      case (sh_op)
        sbrb_pkg::OP_RCR: begin
          if (has_dummy(sh_addr) && !sh_dummy) sh_dummy = 1'b1;
          else r = sh_regs[s];
        end
        sbrb_pkg::OP_WCR: begin sh_regs[s] = b; sh_phase = 2'd0; end
        sbrb_pkg::OP_BFS: begin sh_regs[s] = sh_regs[s] | b; sh_phase = 2'd0; end
        sbrb_pkg::OP_BFC: begin sh_regs[s] = sh_regs[s] & ~b; sh_phase = 2'd0; end
        default: sh_phase = 2'd0;
      endcase
    end else if (sh_phase == 2'd2) begin
      if (sh_op == sbrb_pkg::OP_RBM) begin
        p = ptr_of(ERDPTL);
        r = sh_mem[p % BUF_N];
        if (ai) ptr_store(ERDPTL, (p == ptr_of(ERXNDL)) ? ptr_of(ERXSTL) : ptr_next(p));
      end else begin
        p = ptr_of(EWRPTL);
        sh_mem[p % BUF_N]     = b;
        sh_written[p % BUF_N] = 1'b1;
        if (ai) ptr_store(EWRPTL, ptr_next(p));
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request generation. A data byte that would read a never-written buffer
  // entry is swapped for a register read command.
  // ---------------------------------------------------------------------------
  task automatic put(bit start, logic [7:0] b);
    request_t rq;
    if (!start && sh_phase == 2'd2 && sh_op == sbrb_pkg::OP_RBM &&
        !sh_written[ptr_of(ERDPTL) % BUF_N]) begin
      start = 1'b1;
      b     = {sbrb_pkg::OP_RCR, 5'($urandom)};
    end
    rq.start   = start;
    rq.data    = b;
    rq.miso    = slave_byte(start, b);
    rq.drain   = drain_next;
    drain_next = 1'b0;
    pend_q.push_back(rq);
  endtask

  task automatic cmd(logic [2:0] op, logic [4:0] a);
    put(1'b1, {op, a});
  endtask

  task automatic wr_reg(logic [4:0] a, logic [7:0] v);
    cmd(sbrb_pkg::OP_WCR, a);
    put(1'b0, v);
  endtask

  task automatic sel_bank(logic [1:0] b);
    wr_reg(ECON1_ADR, {sh_regs[sbrb_pkg::SLOT_ECON1][7:2], b});
  endtask

  task automatic set_ptr(logic [4:0] lo, logic [15:0] v);
    sel_bank(2'd0);
    wr_reg(lo, v[7:0]);
    wr_reg(lo + 5'd1, v[15:8]);
  endtask

  task automatic data_bytes(int n);
    repeat (n) put(1'b0, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued requests, holds them while stalled, idles in bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        miso_q.push_back(pend_q[0].miso);
        void'(pend_q.pop_front());
        sent++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pend_q.size() > 0 && !(pend_q[0].drain && miso_q.size() > 0)) begin
          in_valid       <= 1'b1;
          in_frame_start <= pend_q[0].start;
          in_mosi_byte   <= pend_q[0].data;
          if (sent < gap_end && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 8);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each response in order and throttles with stall bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (miso_q.size() == 0) begin
          $error("miso_byte: no response expected, got %02h", out_miso_byte);
          errors++;
        end else begin
          want = miso_q.pop_front();
          if (out_miso_byte !== want) begin
            $error("miso_byte: expected %02h, actual %02h", want, out_miso_byte);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (sent < gap_end && $urandom_range(0, 7) == 0) out_gap = $urandom_range(1, 8);
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] wr_base;
    int          wr_len;
    bit          paused;
    logic [2:0]  rop;
    sh_phase = 2'd0; sh_op = 3'd0; sh_addr = 5'd0; sh_dummy = 1'b0;
    regs_to_defaults();
    for (int i = 0; i < BUF_N; i++) begin
      sh_mem[i] = 8'h00;
      sh_written[i] = 1'b0;
    end
    wr_base = 16'h0000;
    wr_len  = 1;
    paused  = 1'b0;

    // directed part
    put(1'b0, 8'hA5);                          // data byte outside any frame
    cmd(sbrb_pkg::OP_RCR, 5'h1D); data_bytes(2);   // common register, repeated read
    sel_bank(2'd2);
    cmd(sbrb_pkg::OP_RCR, 5'h08); data_bytes(2);   // MAC read: dummy byte first
    cmd(sbrb_pkg::OP_BFS, 5'h09); put(1'b0, 8'hC0); put(1'b0, 8'hFF);  // extra byte ignored
    cmd(sbrb_pkg::OP_BFC, 5'h09); put(1'b0, 8'h07);
    wr_reg(ECON1_ADR, 8'hFF);                  // all ECON1 bits high, bank 3
    cmd(sbrb_pkg::OP_RCR, 5'h12); data_bytes(1);
    cmd(OP_UNUSED, 5'h1F); put(1'b0, 8'h55);
    cmd(sbrb_pkg::OP_SRC, 5'h1F);              // soft reset
    wr_reg(EWRPTL, 8'hFF); wr_reg(EWRPTL + 5'd1, 8'h1F);
    cmd(sbrb_pkg::OP_WBM, 5'h1A);              // ptr wrap
    put(1'b0, 8'h00); put(1'b0, 8'hFF); data_bytes(1);
    wr_reg(ERXSTL, 8'h00); wr_reg(ERXSTL + 5'd1, 8'h00);
    wr_reg(ERDPTL, 8'hFF); wr_reg(ERDPTL + 5'd1, 8'h1F);
    cmd(sbrb_pkg::OP_RBM, 5'h00); data_bytes(3);   // read wraps at rx end
    cmd(sbrb_pkg::OP_BFC, ECON2_ADR); put(1'b0, sbrb_pkg::AUTOINC_BIT);
    cmd(sbrb_pkg::OP_WBM, 5'h00); data_bytes(2);   // no auto increment
    cmd(sbrb_pkg::OP_RBM, 5'h00); data_bytes(2);

    // random part
    while (pend_q.size() < 600) begin
      if (!paused && pend_q.size() > 300) begin
        drain_next = 1'b1;
        paused = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          wr_base = ($urandom_range(0, 15) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(0, BUF_N - 1));
          wr_len  = $urandom_range(1, 12);
          if ($urandom_range(0, 5) == 0) begin
            cmd(sbrb_pkg::OP_BFC, ECON2_ADR); put(1'b0, sbrb_pkg::AUTOINC_BIT);
          end else begin
            cmd(sbrb_pkg::OP_BFS, ECON2_ADR); put(1'b0, sbrb_pkg::AUTOINC_BIT);
          end
          set_ptr(EWRPTL, wr_base);
          cmd(sbrb_pkg::OP_WBM, 5'($urandom)); data_bytes(wr_len);
        end
        2, 3: begin
          set_ptr(ERDPTL, wr_base);
          cmd(sbrb_pkg::OP_RBM, 5'($urandom)); data_bytes($urandom_range(1, wr_len + 2));
        end
        4: begin
          set_ptr(ERXSTL, wr_base);
          set_ptr(ERXNDL, wr_base + 16'(wr_len - 1));
          set_ptr(ERDPTL, wr_base);
          cmd(sbrb_pkg::OP_RBM, 5'($urandom)); data_bytes(2 * wr_len);
        end
        5: begin
          sel_bank(2'($urandom));
          case ($urandom_range(0, 2))
            0: rop = sbrb_pkg::OP_WCR;
            1: rop = sbrb_pkg::OP_BFS;
            default: rop = sbrb_pkg::OP_BFC;
          endcase
          cmd(rop, 5'($urandom)); data_bytes($urandom_range(1, 2));
        end
        6: begin
          sel_bank(2'($urandom));
          cmd(sbrb_pkg::OP_RCR, 5'($urandom)); data_bytes($urandom_range(1, 3));
        end
        7: repeat ($urandom_range(1, 4)) put($urandom_range(0, 2) == 0, 8'($urandom));
        default: begin
          if ($urandom_range(0, 3) == 0) cmd(sbrb_pkg::OP_SRC, 5'($urandom));
          else cmd(3'($urandom), 5'($urandom));
          data_bytes($urandom_range(0, 2));
        end
      endcase
    end
    gap_end = pend_q.size() - 60;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pend_q.size() > 0 || miso_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> spi_banked_register_and_buffer_slave.f
+incdir+sv
sv/sbrb_pkg.sv
sv/sbrb_ram.sv
sv/spi_banked_register_and_buffer_slave.sv
sim/tb_top.sv
